>>> rtl/fpa_pkg.sv
// Package for the fit-policy partition allocator.
// Holds sizes, action/status/policy codes and the search token type.
// Used by fpa_cell and fit_policy_partition_allocator; depends on nothing.
package fpa_pkg;

    // Table size and derived widths.
    localparam int PARTS = 8;
    localparam int IDX_W = (PARTS > 1) ? $clog2(PARTS) : 1;
    localparam int CNT_W = $clog2(PARTS + 1);

    // Field widths fixed by the interface.
    localparam int BASE_W = 32;
    localparam int SIZE_W = 16;

    // Last step of the scan, as a step counter value.
    localparam logic [IDX_W-1:0] LAST_STEP = IDX_W'(PARTS - 1);

    // Full table, as an entry count.
    localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(PARTS);

    // Input transaction actions.
    typedef enum logic [1:0] {
        ACT_CLEAR = 2'd0,
        ACT_ADD   = 2'd1,
        ACT_ALLOC = 2'd2,
        ACT_NONE  = 2'd3
    } t_action;

    // Fit policy register values. The spare code behaves as first fit.
    typedef enum logic [1:0] {
        POL_FIRST = 2'd0,
        POL_BEST  = 2'd1,
        POL_WORST = 2'd2,
        POL_SPARE = 2'd3
    } t_policy;

    // Result status codes.
    typedef enum logic [2:0] {
        ST_DONE    = 3'd0,
        ST_ALLOC   = 3'd1,
        ST_NOFIT   = 3'd2,
        ST_REFUSED = 3'd3,
        ST_FULL    = 3'd4,
        ST_ZERO    = 3'd5
    } t_status;

    // Controller states.
    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_FINISH
    } t_state;

    // Best candidate so far, handed from cell to cell during a scan.
    typedef struct packed {
        logic              found;
        logic [IDX_W-1:0]  idx;
        logic [SIZE_W-1:0] space;
        logic [BASE_W-1:0] base;
        logic [SIZE_W-1:0] used;
    } t_token;

endpackage

>>> rtl/fpa_cell.sv
// One partition cell of the allocator chain: stores one table entry and
// compares it against the search token passing by. Depends on fpa_pkg.
module fpa_cell (
    input  logic                      i_clk,
    input  logic [fpa_pkg::IDX_W-1:0] i_idx,
    input  logic                      i_live,
    input  logic [1:0]                i_policy,
    input  logic [fpa_pkg::SIZE_W-1:0] i_req_size,
    input  fpa_pkg::t_token           i_tok,
    output fpa_pkg::t_token           o_tok,
    input  logic                      i_wr,
    input  logic [fpa_pkg::BASE_W-1:0] i_wr_base,
    input  logic [fpa_pkg::SIZE_W-1:0] i_wr_size,
    input  logic                      i_commit
);

    logic [fpa_pkg::BASE_W-1:0] r_base;
    logic [fpa_pkg::SIZE_W-1:0] r_space;
    logic [fpa_pkg::SIZE_W-1:0] r_used;
    fpa_pkg::t_token            r_tok;
    fpa_pkg::t_token            n_tok;
    logic                       fits;
    logic                       better;

    // Decide whether this entry beats the candidate carried by the token.
    always_comb begin
        fits = i_live && (r_space >= i_req_size);
        if (i_policy == fpa_pkg::POL_BEST && r_space != i_tok.space) begin
            better = r_space < i_tok.space;
        end else if (i_policy == fpa_pkg::POL_WORST && r_space != i_tok.space) begin
            better = r_space > i_tok.space;
        end else begin
            // Equal base keeps the earlier entry, which was added first.
            better = r_base < i_tok.base;
        end
        if (fits && (!i_tok.found || better)) begin
            n_tok.found = 1'b1;
            n_tok.idx   = i_idx;
            n_tok.space = r_space;
            n_tok.base  = r_base;
            n_tok.used  = r_used;
        end else begin
            n_tok = i_tok;
        end
    end

    // Hand the token on to the next cell every cycle.
    always_ff @(posedge i_clk) begin
        r_tok <= n_tok;
    end

    assign o_tok = r_tok;

    // Entry storage: loaded by an add, updated when a grant lands here.
    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_base  <= i_wr_base;
            r_space <= i_wr_size;
            r_used  <= '0;
        end else if (i_commit) begin
            r_space <= r_space - i_req_size;
            r_used  <= r_used + i_req_size;
        end
    end

endmodule

>>> rtl/fit_policy_partition_allocator.sv
// Top level of the fit-policy partition allocator: controller, policy register,
// output register and the chain of partition cells. Depends on fpa_pkg, fpa_cell.

// Clear, add, unused actions, refused requests and zero-size requests finish in the
// cycle they are accepted and show their result on the next cycle. An allocate request
// that needs a search is accepted, then the search token moves one cell per scan step
// down the chain of partition cells; once the output register is free, a finish step
// commits the grant to the chosen cell and loads the result. A new transaction is
// accepted only while the controller is idle; a search may start while the previous
// result still waits to be taken. Ties go to the lowest base, then to the entry added
// first. The fit policy is written through i_cfg_wr_en and is meant to change only
// while the block is idle.
module fit_policy_partition_allocator (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [1:0]  i_cfg_wr_data,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_action,
    input  logic [31:0] i_part_base,
    input  logic [15:0] i_part_size,
    input  logic [15:0] i_req_size,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [2:0]  o_status,
    output logic [31:0] o_grant_base,
    output logic [15:0] o_grant_offset,
    output logic [15:0] o_request_index
);

    localparam int PARTS = fpa_pkg::PARTS;
    localparam int IDX_W = fpa_pkg::IDX_W;
    localparam int CNT_W = fpa_pkg::CNT_W;

    fpa_pkg::t_state   r_state, n_state;
    logic [IDX_W-1:0]  r_step, n_step;
    logic [CNT_W-1:0]  r_count, n_count;
    logic              r_failed, n_failed;
    logic [15:0]       r_req_cnt, n_req_cnt;
    logic [1:0]        r_policy;
    logic [15:0]       r_req_size, n_req_size;
    logic [15:0]       r_ridx, n_ridx;
    logic              r_out_valid, n_out_valid;
    logic [2:0]        r_out_status, n_out_status;
    logic [31:0]       r_out_base, n_out_base;
    logic [15:0]       r_out_offset, n_out_offset;
    logic [15:0]       r_out_index, n_out_index;

    logic              in_accept;
    logic              out_free;
    logic              immediate;
    logic              wr_en;
    logic              commit_en;
    logic              ld;
    logic [2:0]        ld_status;
    logic [31:0]       ld_base;
    logic [15:0]       ld_offset;
    logic [15:0]       ld_index;

    fpa_pkg::t_token   tok_chain [PARTS+1];
    fpa_pkg::t_token   final_tok;

    // Handshake decode. Results produced at once need the output register.
    assign out_free  = !r_out_valid || !i_out_stall;
    assign immediate = (i_action != fpa_pkg::ACT_ALLOC) || r_failed || (i_req_size == '0);
    assign o_in_stall = (r_state != fpa_pkg::S_IDLE) || (!out_free && immediate);
    assign in_accept  = i_in_valid && !o_in_stall;

    // Fit policy register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_policy <= fpa_pkg::POL_FIRST;
        end else if (i_cfg_wr_en) begin
            r_policy <= i_cfg_wr_data;
        end
    end

    // Next state, table control and result loading.
    always_comb begin
        n_state     = r_state;
        n_step      = r_step;
        n_count     = r_count;
        n_failed    = r_failed;
        n_req_cnt   = r_req_cnt;
        n_req_size  = r_req_size;
        n_ridx      = r_ridx;
        wr_en       = 1'b0;
        commit_en   = 1'b0;
        ld          = 1'b0;
        ld_status   = fpa_pkg::ST_DONE;
        ld_base     = '0;
        ld_offset   = '0;
        ld_index    = '0;

        unique case (r_state)
            fpa_pkg::S_IDLE: begin
                if (in_accept) begin
                    unique case (i_action)
                        fpa_pkg::ACT_CLEAR: begin
                            n_count   = '0;
                            n_failed  = 1'b0;
                            n_req_cnt = '0;
                            ld        = 1'b1;
                        end
                        fpa_pkg::ACT_ADD: begin
                            ld = 1'b1;
                            if (r_count == fpa_pkg::FULL_COUNT) begin
                                ld_status = fpa_pkg::ST_FULL;
                            end else begin
                                wr_en   = 1'b1;
                                n_count = r_count + 1'b1;
                            end
                        end
                        fpa_pkg::ACT_ALLOC: begin
                            n_ridx    = r_req_cnt;
                            n_req_cnt = r_req_cnt + 1'b1;
                            if (r_failed) begin
                                ld        = 1'b1;
                                ld_status = fpa_pkg::ST_REFUSED;
                                ld_index  = r_req_cnt;
                            end else if (i_req_size == '0) begin
                                ld        = 1'b1;
                                ld_status = fpa_pkg::ST_ZERO;
                                ld_index  = r_req_cnt;
                            end else begin
                                n_req_size = i_req_size;
                                n_step     = '0;
                                n_state    = fpa_pkg::S_SCAN;
                            end
                        end
                        default: begin
                            ld = 1'b1;
                        end
                    endcase
                end
            end
            fpa_pkg::S_SCAN: begin
                n_step = r_step + 1'b1;
                if (r_step == fpa_pkg::LAST_STEP) begin
                    n_state = fpa_pkg::S_FINISH;
                end
            end
            fpa_pkg::S_FINISH: begin
                if (out_free) begin
                    ld       = 1'b1;
                    ld_index = r_ridx;
                    if (final_tok.found) begin
                        commit_en = 1'b1;
                        ld_status = fpa_pkg::ST_ALLOC;
                        ld_base   = final_tok.base;
                        ld_offset = final_tok.used;
                    end else begin
                        ld_status = fpa_pkg::ST_NOFIT;
                        n_failed  = 1'b1;
                    end
                    n_state = fpa_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = fpa_pkg::S_IDLE;
            end
        endcase

        // Output register: drained by the consumer, loaded with a new result.
        n_out_valid  = r_out_valid && i_out_stall;
        n_out_status = r_out_status;
        n_out_base   = r_out_base;
        n_out_offset = r_out_offset;
        n_out_index  = r_out_index;
        if (ld) begin
            n_out_valid  = 1'b1;
            n_out_status = ld_status;
            n_out_base   = ld_base;
            n_out_offset = ld_offset;
            n_out_index  = ld_index;
        end
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= fpa_pkg::S_IDLE;
            r_step      <= '0;
            r_count     <= '0;
            r_failed    <= 1'b0;
            r_req_cnt   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_step      <= n_step;
            r_count     <= n_count;
            r_failed    <= n_failed;
            r_req_cnt   <= n_req_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_req_size   <= n_req_size;
        r_ridx       <= n_ridx;
        r_out_status <= n_out_status;
        r_out_base   <= n_out_base;
        r_out_offset <= n_out_offset;
        r_out_index  <= n_out_index;
    end

    // A fresh, empty token enters the head of the chain every cycle.
    assign tok_chain[0] = '0;
    assign final_tok    = tok_chain[PARTS];

    // Chain of partition cells.
    for (genvar i = 0; i < PARTS; i++) begin : g_cell
        fpa_cell u_cell (
            .i_clk      (i_clk),
            .i_idx      (IDX_W'(i)),
            .i_live     (CNT_W'(i) < r_count),
            .i_policy   (r_policy),
            .i_req_size (r_req_size),
            .i_tok      (tok_chain[i]),
            .o_tok      (tok_chain[i+1]),
            .i_wr       (wr_en && (r_count == CNT_W'(i))),
            .i_wr_base  (i_part_base),
            .i_wr_size  (i_part_size),
            .i_commit   (commit_en && (final_tok.idx == IDX_W'(i)))
        );
    end

    assign o_out_valid     = r_out_valid;
    assign o_status        = r_out_status;
    assign o_grant_base    = r_out_base;
    assign o_grant_offset  = r_out_offset;
    assign o_request_index = r_out_index;

endmodule
